### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted
`define PSWP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define PSWP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pswp_pkg.sv
// ---------------------------------------------------------------------------
// pswp_pkg
// Shared constants, types and weight-table generation for the N-step
// phase-shifting wrapped-phase block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pswp_pkg;

  // Field and datapath widths
  localparam int unsigned STEPS_DFLT   = 5;
  localparam int          SAMPLE_W     = 16;
  localparam int          PHASE_W      = 16;
  localparam int          MOD_W        = 17;
  localparam int          WEIGHT_W     = 16;
  localparam int          SUM_W        = 40;
  localparam int          ANGLE_W      = 32;
  localparam int          CORDIC_ITERS = 32;
  localparam int          ITER_W       = $clog2(CORDIC_ITERS);

  // Multiplier operand widths (signed)
  localparam int          MUL_A_W      = 22;
  localparam int          MUL_B_W      = 24;
  localparam int          MUL_P_W      = MUL_A_W + MUL_B_W;

  // Modulation scaling: magnitude * (2/gain in Q22) / (steps * 2^37)
  localparam int          XMAG_W       = 39;
  localparam int          XLO_W        = 20;
  localparam int          XHI_W        = XMAG_W - XLO_W;
  localparam int          SCALE_W      = 23;
  localparam int          NUM_W        = 62;
  localparam int          MOD_SHIFT    = 37;
  localparam int          QUO_W        = NUM_W + 1 - MOD_SHIFT;

  localparam logic [SCALE_W-1:0] TWO_OVER_GAIN_Q22 = 23'd5094007;
  localparam logic [MOD_W-1:0]   MOD_MAX           = '1;
  localparam longint             GAIN_INV_Q30      = 64'sd652032874;
  localparam logic [ANGLE_W-1:0] HALF_TURN         = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] PHASE_RND         = 32'h0000_8000;

  // atan(2^-k) in units of 2^-32 turn
  localparam logic [ANGLE_W-1:0] ATAN_TURNS [CORDIC_ITERS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Sequencer states of the top level
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC_C,
    ST_MAC_S,
    ST_FOLD,
    ST_ROT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ROUND,
    ST_DIV,
    ST_DONE
  } state_t;

  // Control and status between the sequencer and the CORDIC unit
  typedef struct packed {
    logic start;
  } cordic_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_sts_t;

  // Round half up from Q30 to Q15 and saturate
  function automatic logic [WEIGHT_W-1:0] to_q15(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767)  r = 64'sd32767;
    if (r < -64'sd32768) r = -64'sd32768;
    return WEIGHT_W'(r);
  endfunction

  // {cos, sin} weight pair in Q1.15 for an angle in 2^-32 turn.
  // Only evaluated at elaboration to build the weight table.
  function automatic logic [2*WEIGHT_W-1:0] weight_pair(input logic [ANGLE_W-1:0] angle);
    logic [1:0]         quad;
    logic [ANGLE_W-1:0] u;
    longint             z;
    longint             x;
    longint             y;
    longint             dx;
    longint             dy;
    longint             c;
    longint             s;
    int                 k;
    quad = 2'((angle + 32'h2000_0000) >> 30);
    u    = angle - {quad, 30'd0};
    z    = longint'(signed'(u));
    x    = GAIN_INV_Q30;
    y    = 0;
    for (k = 0; k < CORDIC_ITERS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ATAN_TURNS[k]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ATAN_TURNS[k]);
      end
    end
    unique case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    return {to_q15(c), to_q15(s)};
  endfunction

endpackage

### rtl/pswp_ifs.sv
// ---------------------------------------------------------------------------
// pswp_ifs
// Valid/ready stream interfaces for the sample input and the result output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pswp_in_if;
  logic                          valid;
  logic                          ready;
  logic [pswp_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pswp_out_if;
  logic                         valid;
  logic                         ready;
  logic [pswp_pkg::PHASE_W-1:0] phase_frac;
  logic [pswp_pkg::MOD_W-1:0]   modulation;

  modport source (output valid, output phase_frac, output modulation, input ready);
  modport sink   (input valid, input phase_frac, input modulation, output ready);
endinterface

### rtl/phase_shift_wrapped_phase.sv
// ---------------------------------------------------------------------------
// phase_shift_wrapped_phase
// N-step phase-shifting demodulator: wrapped phase and modulation per pixel.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : valid/ready stream of 16-bit intensity samples, pixel-major,
//            STEPS samples per pixel back to back.
//   out_ch : one result per pixel: phase_frac (65536 = one turn) and
//            modulation (saturated to 17 bits).
//   A sample is taken in the idle state and then passes two multiply-
//   accumulate steps on the single shared multiplier (cos, then sin).
//   After the last sample of a pixel follow a fold step, the CORDIC
//   (32 micro-rotations), the scaling multiply and rounding, a
//   reciprocal multiply for the division by STEPS, and the load of the
//   output register. A pixel whose sums are both zero skips the CORDIC,
//   the scaling and the division.
//   in_ch.ready is high only while the sequencer is idle.
//   Results sit in an output register; while the receiver stalls, new
//   samples are still taken, and only the finish of the next pixel
//   waits until the register is free.
//   Reset clears the sums, the step counter and the output valid.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module phase_shift_wrapped_phase #(
  parameter int unsigned STEPS = pswp_pkg::STEPS_DFLT
) (
  input  logic      clk,
  input  logic      rst_n,
  pswp_in_if.sink   in_ch,
  pswp_out_if.source out_ch
);
  import pswp_pkg::*;

  localparam int StepW   = $clog2(STEPS);
  // Division by STEPS: quotients in range need QcW bits, reciprocal in Q(RecipSh)
  localparam int QcW     = MOD_W + $clog2(STEPS);
  localparam int RecipSh = QcW + $clog2(STEPS);
  localparam logic [MUL_B_W-1:0] Recip =
    MUL_B_W'(((64'd1 << RecipSh) + 64'(STEPS) - 64'd1) / 64'(STEPS));
  localparam logic [QUO_W-1:0]   SatLim = QUO_W'(64'(STEPS) << MOD_W);

  // Weight table, built at elaboration
  logic signed [WEIGHT_W-1:0] cos_wt [STEPS];
  logic signed [WEIGHT_W-1:0] sin_wt [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_wt
    localparam logic [ANGLE_W-1:0] Angle =
      ANGLE_W'(((64'(g) << 32) + 64'(STEPS / 2)) / 64'(STEPS));
    localparam logic [2*WEIGHT_W-1:0] Pair = weight_pair(Angle);
    assign cos_wt[g] = Pair[2*WEIGHT_W-1:WEIGHT_W];
    assign sin_wt[g] = Pair[WEIGHT_W-1:0];
  end

  // State and datapath registers
  state_t                  state_r;
  state_t                  state_nxt;
  logic [StepW-1:0]        step_r;
  logic [StepW-1:0]        step_nxt;
  logic [SAMPLE_W-1:0]     sample_r;
  logic signed [SUM_W-1:0] cos_sum_r;
  logic signed [SUM_W-1:0] cos_sum_nxt;
  logic signed [SUM_W-1:0] sin_sum_r;
  logic signed [SUM_W-1:0] sin_sum_nxt;
  logic                    zero_r;
  logic                    zero_nxt;
  logic [NUM_W-1:0]        num_r;
  logic [NUM_W-1:0]        num_nxt;
  logic [QUO_W-1:0]        quo_r;
  logic [QUO_W-1:0]        quo_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic [PHASE_W-1:0]      out_phase_r;
  logic [MOD_W-1:0]        out_mod_r;

  // Control decoded from state
  logic        in_rdy;
  logic        load_out;
  logic        out_free;
  logic        last_step;
  logic        sums_zero;
  cordic_ctl_t cordic_ctl;
  cordic_sts_t cordic_sts;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod;

  // CORDIC results and post-processing
  logic signed [SUM_W-1:0] cx;
  logic [ANGLE_W-1:0]      cang;
  logic [ANGLE_W-1:0]      ang_rnd;
  logic [XMAG_W-1:0]       xmag;
  logic [NUM_W:0]          num_rnd;
  logic                    div_sat;
  logic [PHASE_W-1:0]      phase_val;
  logic [MOD_W-1:0]        mod_val;

  assign last_step = (step_r == StepW'(STEPS - 1));
  assign sums_zero = (cos_sum_r == '0) && (sin_sum_r == '0);
  assign out_free  = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_ch.valid) state_nxt = ST_MAC_C;
      ST_MAC_C:  state_nxt = ST_MAC_S;
      ST_MAC_S:  state_nxt = last_step ? ST_FOLD : ST_IDLE;
      ST_FOLD:   state_nxt = sums_zero ? ST_DONE : ST_ROT;
      ST_ROT:    if (cordic_sts.done) state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_rdy           = 1'b0;
    load_out         = 1'b0;
    cordic_ctl.start = 1'b0;
    unique case (state_r)
      ST_IDLE: in_rdy           = 1'b1;
      ST_FOLD: cordic_ctl.start = !sums_zero;
      ST_DONE: load_out         = out_free;
      default: ;
    endcase
  end

  // Vectoring CORDIC unit
  pswp_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cordic_ctl),
    .x_in    (cos_sum_r),
    .y_in    (sin_sum_r),
    .sts     (cordic_sts),
    .x_out   (cx),
    .ang_out (cang)
  );

  // Magnitude clamped at zero
  assign xmag = cx[SUM_W-1] ? '0 : cx[XMAG_W-1:0];

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MAC_C: begin
        mul_a = $signed({{(MUL_A_W - SAMPLE_W){1'b0}}, sample_r});
        mul_b = MUL_B_W'(cos_wt[step_r]);
      end
      ST_MAC_S: begin
        mul_a = $signed({{(MUL_A_W - SAMPLE_W){1'b0}}, sample_r});
        mul_b = MUL_B_W'(sin_wt[step_r]);
      end
      ST_MUL_LO: begin
        mul_a = $signed({{(MUL_A_W - XLO_W){1'b0}}, xmag[XLO_W-1:0]});
        mul_b = $signed({{(MUL_B_W - SCALE_W){1'b0}}, TWO_OVER_GAIN_Q22});
      end
      ST_MUL_HI: begin
        mul_a = $signed({{(MUL_A_W - XHI_W){1'b0}}, xmag[XMAG_W-1:XLO_W]});
        mul_b = $signed({{(MUL_B_W - SCALE_W){1'b0}}, TWO_OVER_GAIN_Q22});
      end
      ST_DIV: begin
        mul_a = $signed({{(MUL_A_W - QcW){1'b0}}, quo_r[QcW-1:0]});
        mul_b = $signed(Recip);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // Rounding offset of steps * 2^36, then drop 37 bits
  assign num_rnd = {1'b0, num_r} + ((NUM_W + 1)'(STEPS) << (MOD_SHIFT - 1));

  // Quotients past the field saturate; the rest divide by reciprocal multiply
  assign div_sat = (quo_r >= SatLim);

  // Datapath next values
  always_comb begin
    step_nxt    = step_r;
    cos_sum_nxt = cos_sum_r;
    sin_sum_nxt = sin_sum_r;
    zero_nxt    = zero_r;
    num_nxt     = num_r;
    quo_nxt     = quo_r;
    unique case (state_r)
      ST_MAC_C: cos_sum_nxt = cos_sum_r + SUM_W'(prod);
      ST_MAC_S: begin
        sin_sum_nxt = sin_sum_r + SUM_W'(prod);
        step_nxt    = last_step ? '0 : step_r + 1'b1;
      end
      ST_FOLD: begin
        zero_nxt    = sums_zero;
        cos_sum_nxt = '0;
        sin_sum_nxt = '0;
      end
      ST_MUL_LO: num_nxt = NUM_W'(prod[XLO_W+SCALE_W-1:0]);
      ST_MUL_HI: num_nxt = num_r + {prod[XHI_W+SCALE_W-1:0], {XLO_W{1'b0}}};
      ST_ROUND:  quo_nxt = num_rnd[NUM_W:MOD_SHIFT];
      ST_DIV:    quo_nxt = div_sat ? '1 : QUO_W'(prod[RecipSh+MOD_W-1:RecipSh]);
      default: ;
    endcase
  end

  // Result formatting
  assign ang_rnd   = cang + PHASE_RND;
  assign phase_val = zero_r ? '0 : ang_rnd[ANGLE_W-1:ANGLE_W-PHASE_W];
  assign mod_val   = zero_r ? '0 :
                     (quo_r[QUO_W-1:MOD_W] != '0) ? MOD_MAX : quo_r[MOD_W-1:0];

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      cos_sum_r   <= '0;
      sin_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cos_sum_r   <= cos_sum_nxt;
      sin_sum_r   <= sin_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      sample_r <= in_ch.sample;
    end
    zero_r <= zero_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    if (load_out) begin
      out_phase_r <= phase_val;
      out_mod_r   <= mod_val;
    end
  end

  assign in_ch.ready       = in_rdy;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.phase_frac = out_phase_r;
  assign out_ch.modulation = out_mod_r;

endmodule

### rtl/pswp_cordic.sv
// ---------------------------------------------------------------------------
// pswp_cordic
// Iterative vectoring CORDIC: one shift-add micro-rotation per cycle,
// returns the scaled magnitude and the angle in 2^-32 turn.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pswp_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pswp_pkg::cordic_ctl_t               ctl,
  input  logic signed [pswp_pkg::SUM_W-1:0]   x_in,
  input  logic signed [pswp_pkg::SUM_W-1:0]   y_in,
  output pswp_pkg::cordic_sts_t               sts,
  output logic signed [pswp_pkg::SUM_W-1:0]   x_out,
  output logic        [pswp_pkg::ANGLE_W-1:0] ang_out
);
  import pswp_pkg::*;

  logic                     busy_r;
  logic                     busy_nxt;
  logic                     done_r;
  logic                     done_nxt;
  logic [ITER_W-1:0]        k_r;
  logic [ITER_W-1:0]        k_nxt;
  logic signed [SUM_W-1:0]  x_r;
  logic signed [SUM_W-1:0]  x_nxt;
  logic signed [SUM_W-1:0]  y_r;
  logic signed [SUM_W-1:0]  y_nxt;
  logic [ANGLE_W-1:0]       ang_r;
  logic [ANGLE_W-1:0]       ang_nxt;
  logic signed [SUM_W-1:0]  dx;
  logic signed [SUM_W-1:0]  dy;

  // Shared shifter pair of the micro-rotation
  assign dx = y_r >>> k_r;
  assign dy = x_r >>> k_r;

  // Load with left half-plane fold, then rotate toward y = 0
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    k_nxt    = k_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    ang_nxt  = ang_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
      if (x_in < 0) begin
        x_nxt   = -x_in;
        y_nxt   = -y_in;
        ang_nxt = HALF_TURN;
      end else begin
        x_nxt   = x_in;
        y_nxt   = y_in;
        ang_nxt = '0;
      end
    end else if (busy_r) begin
      if (y_r > 0) begin
        x_nxt   = x_r + dx;
        y_nxt   = y_r - dy;
        ang_nxt = ang_r + ATAN_TURNS[k_r];
      end else begin
        x_nxt   = x_r - dx;
        y_nxt   = y_r + dy;
        ang_nxt = ang_r - ATAN_TURNS[k_r];
      end
      k_nxt = k_r + 1'b1;
      if (k_r == ITER_W'(CORDIC_ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      k_r    <= k_nxt;
    end
  end

  // Vector registers
  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    ang_r <= ang_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign x_out    = x_r;
  assign ang_out  = ang_r;

endmodule

### rtl/pswp_checker.sv
// ---------------------------------------------------------------------------
// pswp_checker
// Port-level checks of the wrapped-phase block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pswp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A result held back by the receiver stays offered
  `PSWP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "out valid dropped")

  // Reset empties the output register
  `PSWP_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_valid, "out valid after reset")

  // Ready drops right after a sample transfer, while the sample occupies the multiplier
  `PSWP_ASSERT(a_busy_after, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready right after transfer")

  // A new result never appears directly after a sample transfer
  `PSWP_ASSERT(a_rise_gap, clk, rst_n, $rose(out_valid) |-> !$past(in_valid && in_ready), "result too early")

endmodule

bind phase_shift_wrapped_phase pswp_checker u_pswp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
